// ----- src/mqsb_pkg.sv -----
// Shared types, constants and helpers for the multi-queue shared buffer.
// Depends on nothing; every other file of the block imports it.
package mqsb_pkg;

  // Sizing of the shared slot store and the set of queues.
  localparam int NUM_SLOTS  = 16;
  localparam int NUM_QUEUES = 4;

  // Fixed field widths of the channels.
  localparam int QUEUE_ID_W = 2;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;

  // Slot index width, pointer width (one more code for null) and queue index width.
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  // The null pointer is the first code past the last slot.
  localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(NUM_SLOTS);

  // Depth of the command queue between front and back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Action codes on the input channel.
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  // A classified command handed from the front to the back.
  typedef struct packed {
    logic                      is_deq;
    logic [QIDX_W-1:0]         qidx;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // A pointer names a real slot only when it is below the slot count.
  function automatic logic is_slot(logic [PTR_W-1:0] p);
    return p < PTR_NULL;
  endfunction

  // Reduce a queue number modulo the queue count by repeated subtraction.
  function automatic logic [QIDX_W-1:0] queue_index(logic [QUEUE_ID_W-1:0] id);
    logic [8:0] r;
    r = 9'(id);
    for (int k = 0; k < (1 << QUEUE_ID_W); k++) begin
      if (r >= 9'(NUM_QUEUES)) begin
        r = r - 9'(NUM_QUEUES);
      end
    end
    return r[QIDX_W-1:0];
  endfunction

endpackage

// ----- src/mqsb_in_if.sv -----
// Input channel of the multi-queue shared buffer: valid, ready and one command item.
// Depends on mqsb_pkg for the field widths.
interface mqsb_in_if;
  import mqsb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [QUEUE_ID_W-1:0]     queue_id;
  logic signed [VALUE_W-1:0] value_in;

  modport source (output valid, output action, output queue_id, output value_in,
                  input ready);
  modport sink   (input valid, input action, input queue_id, input value_in,
                  output ready);
endinterface

// ----- src/mqsb_out_if.sv -----
// Output channel of the multi-queue shared buffer: valid, ready and one result item.
// Depends on mqsb_pkg for the field widths.
interface mqsb_out_if;
  import mqsb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output value_out, output status, input ready);
  modport sink   (input valid, input value_out, input status, output ready);
endinterface

// ----- src/mqsb_front.sv -----
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on mqsb_pkg and mqsb_in_if.
module mqsb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  mqsb_in_if.sink        in_i,
  output mqsb_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);
  import mqsb_pkg::*;

  cmd_t                  cmdq_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] count_q, count_d;
  logic                  push;
  logic                  pop;
  cmd_t                  cmd_new;

  // Decode the raw item into a command with a reduced queue index.
  always_comb begin
    cmd_new.is_deq = (in_i.action == ACT_DEQ);
    cmd_new.qidx   = queue_index(in_i.queue_id);
    cmd_new.value  = in_i.value_in;
  end

  // Handshakes on both sides of the command queue.
  assign in_i.ready  = (count_q != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = cmdq_q[rd_ptr_q];

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      cmdq_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- src/mqsb_back.sv -----
// Back end: executes enqueue and dequeue commands on the linked slot store
// and holds the result item in an output register. Depends on mqsb_pkg, mqsb_out_if.
module mqsb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mqsb_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  mqsb_out_if.source     out_o
);
  import mqsb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;

  // Queue pointers, link table and free-list head.
  logic [PTR_W-1:0] head_q [NUM_QUEUES];
  logic [PTR_W-1:0] tail_q [NUM_QUEUES];
  logic [PTR_W-1:0] link_q [NUM_SLOTS];
  logic [PTR_W-1:0] free_head_q, free_head_d;

  // Slot data memory with a registered read port.
  logic signed [VALUE_W-1:0] slot_mem [NUM_SLOTS];
  logic signed [VALUE_W-1:0] rd_data_q;

  // Per-command control.
  logic              exec;
  logic [PTR_W-1:0]  head_cur;
  logic [PTR_W-1:0]  tail_cur;
  logic [PTR_W-1:0]  slot;
  logic              head_we;
  logic [PTR_W-1:0]  head_wdata;
  logic              tail_we;
  logic              link_a_we;
  logic [SLOT_W-1:0] link_a_addr;
  logic [PTR_W-1:0]  link_a_data;
  logic              link_b_we;
  logic [SLOT_W-1:0] link_b_addr;
  logic [PTR_W-1:0]  link_b_data;
  logic              data_we;
  logic              rd_en;
  status_e           status_d, status_q;
  logic              deq_ok_d, deq_ok_q;

  // Output register.
  logic                      out_free;
  logic                      out_load;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [STATUS_W-1:0]       out_status_q;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign exec        = cmd_ready_o && cmd_valid_i;
  assign head_cur    = head_q[cmd_i.qidx];
  assign tail_cur    = tail_q[cmd_i.qidx];
  assign slot        = cmd_i.is_deq ? head_cur : free_head_q;

  // Work out every pointer update of one command in its execute cycle.
  always_comb begin
    free_head_d = free_head_q;
    head_we     = 1'b0;
    head_wdata  = slot;
    tail_we     = 1'b0;
    link_a_we   = 1'b0;
    link_a_addr = slot[SLOT_W-1:0];
    link_a_data = PTR_NULL;
    link_b_we   = 1'b0;
    link_b_addr = tail_cur[SLOT_W-1:0];
    link_b_data = slot;
    data_we     = 1'b0;
    rd_en       = 1'b0;
    status_d    = STATUS_OK;
    deq_ok_d    = 1'b0;
    if (exec) begin
      if (!cmd_i.is_deq) begin
        if (!is_slot(slot)) begin
          status_d = STATUS_OVERFLOW;
        end else begin
          // Take the first free slot and append it to the queue's chain.
          free_head_d = link_q[slot[SLOT_W-1:0]];
          if (!is_slot(head_cur)) begin
            head_we = 1'b1;
          end else if (is_slot(tail_cur)) begin
            link_b_we = 1'b1;
          end
          link_a_we = 1'b1;
          tail_we   = 1'b1;
          data_we   = 1'b1;
        end
      end else begin
        if (!is_slot(slot)) begin
          status_d = STATUS_UNDERFLOW;
        end else begin
          // Unlink the head slot and push it onto the free list.
          head_we     = 1'b1;
          head_wdata  = link_q[slot[SLOT_W-1:0]];
          link_a_we   = 1'b1;
          link_a_data = free_head_q;
          free_head_d = slot;
          rd_en       = 1'b1;
          deq_ok_d    = 1'b1;
        end
      end
    end
  end

  // Sequencer: execute a command, then hand its result to the output register.
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (state_q == ST_RESP) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (exec) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers and pointer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= PTR_NULL;
        tail_q[i] <= PTR_NULL;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        link_q[i] <= PTR_W'(i + 1);
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (head_we) begin
        head_q[cmd_i.qidx] <= head_wdata;
      end
      if (tail_we) begin
        tail_q[cmd_i.qidx] <= slot;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (link_a_we && (link_a_addr == SLOT_W'(i))) begin
          link_q[i] <= link_a_data;
        end else if (link_b_we && (link_b_addr == SLOT_W'(i))) begin
          link_q[i] <= link_b_data;
        end
      end
    end
  end

  // Slot data memory: a write for an enqueue, a registered read for a dequeue.
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      slot_mem[slot[SLOT_W-1:0]] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_data_q <= slot_mem[slot[SLOT_W-1:0]];
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q <= status_d;
      deq_ok_q <= deq_ok_d;
    end
    if (out_load) begin
      out_value_q  <= deq_ok_q ? rd_data_q : '0;
      out_status_q <= status_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = out_value_q;
  assign out_o.status    = out_status_q;

endmodule

// ----- src/multi_queue_shared_buffer.sv -----
// Top level of the multi-queue shared buffer: front end, command queue and back end.
// Depends on mqsb_pkg, mqsb_in_if, mqsb_out_if, mqsb_front and mqsb_back.
//
//   Channel  Direction  Payload                          Handshake
//   in_i     sink       action, queue_id, value_in       valid/ready
//   out_o    source     value_out, status                valid/ready
//
// In the back end each item passes through ST_IDLE, which reads and updates the link
// table, queue pointers and free-list head, then ST_RESP, which moves the result to
// the output. The free-list head and queue pointers written by one item feed the
// next, so no new item enters before the last leaves ST_RESP. Reset is asynchronous
// and active low and leaves every queue empty with all slots on the free list; no
// clearing pass. Up to two items wait in the command queue while the output stalls.
module multi_queue_shared_buffer (
  input  logic   clk_i,
  input  logic   rst_ni,
  mqsb_in_if.sink    in_i,
  mqsb_out_if.source out_o
);
  import mqsb_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // Accept and classify items.
  mqsb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  // Execute commands on the shared slot store.
  mqsb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule
